### rtl/balsm_pkg.sv
// shared types and constants for the byte-addressed load/store memory
package balsm_pkg;

	localparam int unsigned MEMORY_BYTES_DEF = 65536;

	localparam logic [2:0] KIND_BYTE_S = 3'd0;
	localparam logic [2:0] KIND_BYTE_U = 3'd1;
	localparam logic [2:0] KIND_HALF_S = 3'd2;
	localparam logic [2:0] KIND_HALF_U = 3'd3;
	localparam logic [2:0] KIND_WORD   = 3'd4;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_STORE = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_RANGE    = 2'd1,
		STAT_MISALIGN = 2'd2,
		STAT_INVALID  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	// access size in bytes, zero for an unknown kind
	function automatic logic [2:0] kind_size(input logic [2:0] kind);
		logic [2:0] sz;
		case (kind)
			KIND_BYTE_S, KIND_BYTE_U: sz = 3'd1;
			KIND_HALF_S, KIND_HALF_U: sz = 3'd2;
			KIND_WORD: sz = 3'd4;
			default: sz = 3'd0;
		endcase
		return sz;
	endfunction

endpackage

### rtl/byte_addressed_load_store_memory_top.sv
// byte-addressed little-endian load/store memory with one word-wide ram
// result is registered, valid in the cycle after the input transfer; throughput one
// access per cycle unless the output stalls, set by the single-ported word ram with
// per-byte write enables and a registered read. result sits in an output register;
// a new access is taken while it drains. after reset the ram is cleared one word per
// cycle, ceil(MEMORY_BYTES/4) words (16384 by default), in_ready low till the pass ends.
module byte_addressed_load_store_memory_top
	import balsm_pkg::*;
#(
	parameter int unsigned MEMORY_BYTES = MEMORY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [31:0] address,
	input  logic [2:0]  access_kind,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic [1:0]  status
);

	localparam int unsigned WORDS   = (MEMORY_BYTES + 3) / 4;
	localparam int unsigned WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);
	localparam logic [32:0] MEM_LIMIT = 33'(MEMORY_BYTES);

	logic [31:0] mem [0:WORDS-1];

	state_t             state_q;
	logic [WORD_AW-1:0] clr_q;

	logic               out_valid_q;
	logic               op_s1;
	logic [2:0]         kind_s1;
	logic [1:0]         off_s1;
	status_t            status_s1;
	logic [31:0]        rdata_s1;

	logic               accept;
	logic [2:0]         size;
	logic [2:0]         span;
	logic [32:0]        end_addr;
	status_t            chk;
	logic               ok;
	logic               wr_en;
	logic               rd_en;
	logic [WORD_AW-1:0] widx;
	logic [3:0]         be;
	logic [31:0]        wdata;
	logic [7:0]         lane_b;
	logic [15:0]        lane_h;
	logic [31:0]        load_val;

	assign in_ready = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// range first, then kind, then alignment
	always_comb begin
		size     = kind_size(access_kind);
		span     = (size == 3'd0) ? 3'd1 : size;
		end_addr = {1'b0, address} + {30'd0, span};
		if (end_addr > MEM_LIMIT) begin
			chk = STAT_RANGE;
		end else if (size == 3'd0) begin
			chk = STAT_INVALID;
		end else if ((size == 3'd2 && address[0]) ||
				(size == 3'd4 && address[1:0] != 2'b00)) begin
			chk = STAT_MISALIGN;
		end else begin
			chk = STAT_OK;
		end
	end

	assign ok    = (chk == STAT_OK);
	assign wr_en = accept && ok && (op == OP_STORE);
	assign rd_en = accept && ok && (op == OP_LOAD);
	assign widx  = address[WORD_AW+1:2];

	always_comb begin
		case (size)
			3'd1: begin
				be    = 4'b0001 << address[1:0];
				wdata = {4{write_data[7:0]}};
			end
			3'd2: begin
				be    = address[1] ? 4'b1100 : 4'b0011;
				wdata = {2{write_data[15:0]}};
			end
			3'd4: begin
				be    = 4'b1111;
				wdata = write_data;
			end
			default: begin
				be    = 4'b0000;
				wdata = write_data;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			mem[clr_q] <= 32'd0;
		end else if (wr_en) begin
			for (int i = 0; i < 4; i++) begin
				if (be[i]) begin
					mem[widx][8*i +: 8] <= wdata[8*i +: 8];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[widx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == LAST_WORD) begin
						state_q <= ST_RUN;
					end
					clr_q <= clr_q + 1'b1;
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
					clr_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			kind_s1   <= access_kind;
			off_s1    <= address[1:0];
			status_s1 <= chk;
		end
	end

	// pick the addressed lanes and extend
	always_comb begin
		lane_b = rdata_s1[8*off_s1 +: 8];
		lane_h = off_s1[1] ? rdata_s1[31:16] : rdata_s1[15:0];
		case (kind_s1)
			KIND_BYTE_S: load_val = {{24{lane_b[7]}}, lane_b};
			KIND_BYTE_U: load_val = {24'd0, lane_b};
			KIND_HALF_S: load_val = {{16{lane_h[15]}}, lane_h};
			KIND_HALF_U: load_val = {16'd0, lane_h};
			KIND_WORD: load_val = rdata_s1;
			default: load_val = 32'd0;
		endcase
	end

	assign out_valid = out_valid_q;
	assign read_data = (status_s1 == STAT_OK && op_s1 == OP_LOAD) ? load_val : 32'd0;
	assign status    = status_s1;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_ready)
		else $error("input taken during clear pass");

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_RUN)
		else $error("store during clear pass");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("transfer without result");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> read_data == 32'd0)
		else $error("failed access returned data");

	a_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op_s1 == OP_STORE |-> read_data == 32'd0)
		else $error("store returned data");

endmodule

### tb/tb_byte_addressed_load_store_memory_top.sv
// self-checking testbench for the byte-addressed load/store memory top level
module tb_byte_addressed_load_store_memory_top;
	timeunit 1ns;
	timeprecision 1ps;

	import balsm_pkg::*;

	localparam int unsigned MEM_BYTES = MEMORY_BYTES_DEF;
	localparam int RANDOM_ITEMS = 1000;
	localparam int MAX_REPORTS = 10;
	localparam logic [2:0] KIND_RSVD5 = 3'd5;
	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;

	typedef struct packed {
		logic        op;
		logic [31:0] addr;
		logic [2:0]  kind;
		logic [31:0] wdata;
		logic        typed;
		logic [31:0] rd;
		status_t     st;
	} access_row_t;

	typedef struct packed {
		logic [31:0] rd;
		status_t     st;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	logic [31:0] address;
	logic [2:0]  access_kind;
	logic [31:0] write_data;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] read_data;
	logic [1:0]  status;

	logic [7:0] mem_model [0:MEM_BYTES-1];
	result_t    pending_results [$];
	int         mismatches = 0;
	bit         quiet_in = 0;
	bit         quiet_out = 0;

	localparam int DIRECTED_ROWS = 27;
	access_row_t directed_rows [DIRECTED_ROWS] = '{
		'{OP_LOAD,  32'h0000_0000, KIND_WORD,   32'h0000_0000, 1'b1, 32'h0, STAT_OK},
		'{OP_LOAD,  32'h0000_ffff, KIND_BYTE_S, 32'h0000_0000, 1'b1, 32'h0, STAT_OK},
		'{OP_STORE, 32'h0000_0000, KIND_WORD,   32'hffff_ffff, 1'b1, 32'h0, STAT_OK},
		'{OP_LOAD,  32'h0000_0000, KIND_BYTE_S, 32'h0000_0000, 1'b0, 32'h0, STAT_OK},
		'{OP_LOAD,  32'h0000_0000, KIND_BYTE_U, 32'h0000_0000, 1'b0, 32'h0, STAT_OK},
		'{OP_LOAD,  32'h0000_0002, KIND_HALF_S, 32'h0000_0000, 1'b0, 32'h0, STAT_OK},
		'{OP_LOAD,  32'h0000_0002, KIND_HALF_U, 32'h0000_0000, 1'b0, 32'h0, STAT_OK},
		'{OP_STORE, 32'h0000_0001, KIND_BYTE_U, 32'h1234_5600, 1'b0, 32'h0, STAT_OK},
		'{OP_LOAD,  32'h0000_0000, KIND_WORD,   32'h0000_0000, 1'b0, 32'h0, STAT_OK},
		'{OP_STORE, 32'h0000_0004, KIND_HALF_S, 32'habcd_8001, 1'b0, 32'h0, STAT_OK},
		'{OP_LOAD,  32'h0000_0004, KIND_HALF_S, 32'h0000_0000, 1'b0, 32'h0, STAT_OK},
		'{OP_STORE, 32'h0000_fffc, KIND_WORD,   32'h8001_7f01, 1'b0, 32'h0, STAT_OK},
		'{OP_LOAD,  32'h0000_fffc, KIND_WORD,   32'h0000_0000, 1'b0, 32'h0, STAT_OK},
		'{OP_STORE, 32'h0000_ffff, KIND_BYTE_S, 32'hffff_ff7e, 1'b0, 32'h0, STAT_OK},
		'{OP_LOAD,  32'h0000_ffff, KIND_BYTE_S, 32'h0000_0000, 1'b0, 32'h0, STAT_OK},
		'{OP_LOAD,  32'h0001_0000, KIND_WORD,   32'h0000_0000, 1'b1, 32'h0, STAT_RANGE},
		'{OP_STORE, 32'hffff_ffff, KIND_BYTE_U, 32'hffff_ffff, 1'b1, 32'h0, STAT_RANGE},
		'{OP_LOAD,  32'h0000_ffff, KIND_HALF_U, 32'h0000_0000, 1'b1, 32'h0, STAT_RANGE},
		'{OP_STORE, 32'h0000_fffe, KIND_WORD,   32'hffff_ffff, 1'b1, 32'h0, STAT_RANGE},
		'{OP_LOAD,  32'h0000_0001, KIND_HALF_S, 32'h0000_0000, 1'b1, 32'h0, STAT_MISALIGN},
		'{OP_STORE, 32'h0000_0002, KIND_WORD,   32'h5555_aaaa, 1'b1, 32'h0, STAT_MISALIGN},
		'{OP_LOAD,  32'h0000_0003, KIND_WORD,   32'h0000_0000, 1'b1, 32'h0, STAT_MISALIGN},
		'{OP_LOAD,  32'h0000_0000, KIND_RSVD5,  32'h0000_0000, 1'b1, 32'h0, STAT_INVALID},
		'{OP_STORE, 32'h0000_0008, KIND_RSVD7,  32'hffff_ffff, 1'b1, 32'h0, STAT_INVALID},
		'{OP_LOAD,  32'h0001_0000, KIND_RSVD6,  32'h0000_0000, 1'b1, 32'h0, STAT_RANGE},
		'{OP_LOAD,  32'h0000_ffff, KIND_RSVD6,  32'h0000_0000, 1'b1, 32'h0, STAT_INVALID},
		'{OP_LOAD,  32'h0000_0000, KIND_WORD,   32'h0000_0000, 1'b0, 32'h0, STAT_OK}
	};

	byte_addressed_load_store_memory_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.address(address),
		.access_kind(access_kind),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(3_000_000);
		$display("FAILURE");
		$finish;
	end

	function automatic int unsigned access_bytes(input logic [2:0] kind);
		case (kind)
			KIND_BYTE_S, KIND_BYTE_U: return 1;
			KIND_HALF_S, KIND_HALF_U: return 2;
			KIND_WORD: return 4;
			default: return 0;
		endcase
	endfunction

	// applies one access to the byte array and returns what the memory should answer
	function automatic result_t memory_access(input access_row_t a);
		result_t     r;
		int unsigned nbytes;
		int unsigned i;
		logic [32:0] span_end;
		logic [31:0] word;
		nbytes = access_bytes(a.kind);
		span_end = {1'b0, a.addr} + ((nbytes == 0) ? 33'd1 : 33'(nbytes));
		r.rd = '0;
		word = '0;
		if (span_end > 33'(MEM_BYTES))
			r.st = STAT_RANGE;
		else if (nbytes == 0)
			r.st = STAT_INVALID;
		else if ((a.addr & (nbytes - 1)) != 0)
			r.st = STAT_MISALIGN;
		else begin
			r.st = STAT_OK;
			for (i = 0; i < nbytes; i++) begin
				if (a.op == OP_STORE)
					mem_model[a.addr + i] = a.wdata[8*i +: 8];
				else
					word[8*i +: 8] = mem_model[a.addr + i];
			end
			if (a.op == OP_LOAD) begin
				case (a.kind)
					KIND_BYTE_S: r.rd = {{24{word[7]}}, word[7:0]};
					KIND_BYTE_U: r.rd = {24'h0, word[7:0]};
					KIND_HALF_S: r.rd = {{16{word[15]}}, word[15:0]};
					KIND_HALF_U: r.rd = {16'h0, word[15:0]};
					default: r.rd = word;
				endcase
			end
		end
		return r;
	endfunction

	// mostly legal accesses in a small window so loads see earlier stores
	function automatic access_row_t random_access();
		access_row_t a;
		int unsigned pick;
		int unsigned nbytes;
		a = '0;
		pick = $urandom_range(0, 99);
		a.op = 1'($urandom_range(0, 1));
		a.wdata = $urandom;
		a.kind = 3'($urandom_range(KIND_BYTE_S, KIND_WORD));
		nbytes = access_bytes(a.kind);
		if (pick < 60)
			a.addr = $urandom_range(0, 127) & ~(nbytes - 1);
		else if (pick < 70)
			a.addr = $urandom_range(0, MEM_BYTES - 1) & ~(nbytes - 1);
		else if (pick < 76)
			a.addr = MEM_BYTES - $urandom_range(1, 8);
		else if (pick < 85) begin
			a.kind = 3'($urandom_range(KIND_HALF_S, KIND_WORD));
			nbytes = access_bytes(a.kind);
			a.addr = ($urandom_range(0, 127) & ~(nbytes - 1)) + $urandom_range(1, nbytes - 1);
		end else if (pick < 92) begin
			a.kind = 3'($urandom_range(KIND_RSVD5, KIND_RSVD7));
			a.addr = $urandom_range(0, MEM_BYTES - 1);
		end else begin
			a.kind = 3'($urandom_range(KIND_BYTE_S, KIND_RSVD7));
			a.addr = $urandom;
		end
		return a;
	endfunction

	// entered and left at a falling edge
	task automatic send_access(input access_row_t a);
		int      gap;
		result_t r;
		gap = quiet_in ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= a.op;
		address <= a.addr;
		access_kind <= a.kind;
		write_data <= a.wdata;
		do @(posedge clk); while (in_ready !== 1'b1);
		r = memory_access(a);
		if (a.typed) begin
			r.rd = a.rd;
			r.st = a.st;
		end
		pending_results.push_back(r);
		@(negedge clk);
	endtask

	initial begin
		int unsigned k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_LOAD;
		address = '0;
		access_kind = KIND_BYTE_S;
		write_data = '0;
		for (k = 0; k < MEM_BYTES; k++)
			mem_model[k] = 8'h00;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		for (int n = 0; n < DIRECTED_ROWS; n++)
			send_access(directed_rows[n]);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				quiet_in = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_ITEMS / 2) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (pending_results.size() != 0);
			end
			send_access(random_access());
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				quiet_out = !quiet_out;
			stall = quiet_out ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with none pending: read_data %h status %0d",
						$time, read_data, status);
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.rd || status !== want.st) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: read_data exp %h got %h, status exp %0d got %0d",
							$time, want.rd, read_data, want.st, status);
				end
			end
		end
	end

endmodule
